[rtl/pooled_bump_allocator_assert.svh]
// assertion macros for the pooled bump allocator checker
// expects clk and rst_n to be visible where a macro is used
`ifndef POOLED_BUMP_ALLOCATOR_ASSERT_SVH
`define POOLED_BUMP_ALLOCATOR_ASSERT_SVH

// same-cycle implication, disabled in reset
`define PBA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pba assertion failed");

// next-cycle implication, disabled in reset
`define PBA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pba assertion failed");

`endif

[rtl/pba_pkg.sv]
// shared types and constants for the pooled bump allocator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package pba_pkg;
    localparam int POOL_SLOTS_DEF  = 12;
    localparam int CHUNK_BYTES_DEF = 20480;
    localparam int DW              = 32;
    localparam int DIV_AW          = 34;

    // request codes
    localparam logic [1:0] ACT_RESTART = 2'd0;
    localparam logic [1:0] ACT_RAW     = 2'd1;
    localparam logic [1:0] ACT_POOL    = 2'd2;
    localparam logic [1:0] ACT_NONE    = 2'd3;

    // result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NO_GROW   = 3'd1;
    localparam logic [2:0] ST_LIMIT     = 3'd2;
    localparam logic [2:0] ST_NO_POOL   = 3'd3;
    localparam logic [2:0] ST_ZERO_ITEM = 3'd4;

    // configuration register indexes
    localparam logic [1:0] CFG_START = 2'd0;
    localparam logic [1:0] CFG_GROW  = 2'd1;
    localparam logic [1:0] CFG_LIMIT = 2'd2;

    localparam logic [31:0] START_RST = 32'd25165824;
    localparam logic [31:0] GROW_RST  = 32'd1048576;
    localparam logic [31:0] LIMIT_RST = 32'd0;

    // one pool table entry
    typedef struct packed {
        logic [DW-1:0] item_size;
        logic [DW-1:0] remaining;
        logic [DW-1:0] next_offset;
    } pba_entry_t;
endpackage
`default_nettype wire

[rtl/pba_if.sv]
// request and result channel interfaces
// depends on pba_pkg
`timescale 1ns / 1ps
`default_nettype none
interface pba_req_if;
    import pba_pkg::*;
    logic          valid;
    logic          ready;
    logic [1:0]    action;
    logic [DW-1:0] byte_count;
    logic [DW-1:0] alignment;
    modport source (output valid, action, byte_count, alignment, input ready);
    modport sink   (input valid, action, byte_count, alignment, output ready);
endinterface

interface pba_rsp_if;
    import pba_pkg::*;
    logic          valid;
    logic          ready;
    logic [2:0]    status;
    logic [DW-1:0] location;
    modport source (output valid, status, location, input ready);
    modport sink   (input valid, status, location, output ready);
endinterface
`default_nettype wire

[rtl/pba_div.sv]
// serial restoring divider, one quotient bit per cycle
// depends on pba_pkg
`timescale 1ns / 1ps
`default_nettype none
module pba_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [pba_pkg::DIV_AW-1:0] dividend,
    input  wire logic [pba_pkg::DW-1:0]     divisor,
    output logic                            done,
    output logic [pba_pkg::DIV_AW-1:0]      quotient,
    output logic [pba_pkg::DW-1:0]          remainder
);
    import pba_pkg::*;
    localparam int CW = $clog2(DIV_AW + 1);

    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DW:0]       rem_reg, rem_next;
    logic [DIV_AW-1:0] quo_reg, quo_next;
    logic [DW-1:0]     div_reg, div_next;
    logic [DW:0]       trial;

    // one shift-subtract step
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        trial     = {rem_reg[DW-1:0], quo_reg[DIV_AW-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(DIV_AW);
            rem_next  = '0;
            quo_next  = dividend;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = trial - {1'b0, div_reg};
                quo_next = {quo_reg[DIV_AW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[DIV_AW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg[DW-1:0];
endmodule
`default_nettype wire

[rtl/pooled_bump_allocator.sv]
// pooled bump allocator: bump-pointer space allocator with size-class pools
// req: action 0 restart, 1 raw allocate, 2 pool allocate; action 3 is dropped
// rsp: one transaction per request other than a dropped one (status, location)
// config: cfg_we/cfg_index/cfg_data; the user must write it only while the
// block is idle, the block itself does not enforce this
// one request at a time; a restart or zero item size goes straight to the
// output register, a raw request runs up to two divisions (alignment
// remainder and grow rounding), a pool request scans the pool table, reading
// one entry at a time from its memory, and item count, alignment, growth and
// item index each run through the shared serial divider
// the next request is taken while a result still waits in the output register
// the result stage then holds until the receiver takes the waiting transaction
// reset: used bytes 0, workspace from the start size reset value, all pools
// unclaimed through per-entry valid bits; config registers take reset values
// depends on pba_pkg, pba_if, pba_div
`timescale 1ns / 1ps
`default_nettype none
module pooled_bump_allocator #(
    parameter int POOL_SLOTS  = pba_pkg::POOL_SLOTS_DEF,
    parameter int CHUNK_BYTES = pba_pkg::CHUNK_BYTES_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [1:0]             cfg_index,
    input  wire logic [pba_pkg::DW-1:0] cfg_data,
    pba_req_if.sink                     req,
    pba_rsp_if.source                   rsp
);
    import pba_pkg::*;

    localparam int SW = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
    localparam logic [SW-1:0] LAST_SLOT = SW'(POOL_SLOTS - 1);
    localparam logic [DW-1:0] CHUNK_W   = DW'(CHUNK_BYTES);

    // sequencer states
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_SCAN_RD = 4'd1;
    localparam logic [3:0] S_SCAN_CK = 4'd2;
    localparam logic [3:0] S_POOL    = 4'd3;
    localparam logic [3:0] S_CNT     = 4'd4;
    localparam logic [3:0] S_ALN     = 4'd5;
    localparam logic [3:0] S_ALN_WT  = 4'd6;
    localparam logic [3:0] S_FIT     = 4'd7;
    localparam logic [3:0] S_GROW_WT = 4'd8;
    localparam logic [3:0] S_GROW_CK = 4'd9;
    localparam logic [3:0] S_IDX     = 4'd10;
    localparam logic [3:0] S_IDX_WT  = 4'd11;
    localparam logic [3:0] S_DONE    = 4'd12;

    logic [3:0]      state_reg, state_next;
    logic [DW-1:0]   start_size_reg, grow_step_reg, size_limit_reg;
    logic [DW-1:0]   used_reg, used_next;
    logic [DW-1:0]   ws_reg, ws_next;
    logic            pool_mode_reg, pool_mode_next;
    logic [DW-1:0]   item_reg, item_next;
    logic [DW-1:0]   size_reg, size_next;
    logic [DW-1:0]   aln_reg, aln_next;
    logic [SW-1:0]   idx_reg, idx_next;
    logic [SW-1:0]   slot_reg, slot_next;
    logic [SW-1:0]   empty_reg, empty_next;
    logic            empty_ok_reg, empty_ok_next;
    logic            claim_reg, claim_next;
    logic [DW-1:0]   rem_reg, rem_next;
    logic [DW-1:0]   nxt_reg, nxt_next;
    logic [DW-1:0]   cnt_reg, cnt_next;
    logic [DW:0]     start_reg, start_next;
    logic [DW+1:0]   end_reg, end_next;
    logic [DW+2:0]   added_reg, added_next;
    logic [2:0]      res_st_reg, res_st_next;
    logic [DW-1:0]   res_loc_reg, res_loc_next;
    logic            out_vld_reg, out_vld_next;
    logic [2:0]      out_st_reg;
    logic [DW-1:0]   out_loc_reg;
    logic            out_load;

    // pool table memory with per-entry valid bits
    pba_entry_t      mem [POOL_SLOTS];
    logic [POOL_SLOTS-1:0] vld_reg;
    pba_entry_t      rd_data_reg;
    logic            rd_vld_reg;
    logic            rd_en;
    logic            wr_en;
    pba_entry_t      wr_data;
    logic            clr_all;
    pba_entry_t      cur;

    // divider
    logic              div_start;
    logic              div_done;
    logic [DIV_AW-1:0] div_a;
    logic [DW-1:0]     div_b;
    logic [DIV_AW-1:0] div_q;
    logic [DW-1:0]     div_r;

    logic          accept;
    logic [DW+1:0] need;
    logic [DW+3:0] new_ws;

    pba_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_a),
        .divisor   (div_b),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign cur       = rd_vld_reg ? rd_data_reg : '0;
    assign need      = end_reg - {2'b00, ws_reg};
    assign new_ws    = {4'b0000, ws_reg} + {1'b0, added_reg};
    assign out_load  = (state_reg == S_DONE) && (!out_vld_reg || rsp.ready);

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        used_next     = used_reg;
        ws_next       = ws_reg;
        pool_mode_next = pool_mode_reg;
        item_next     = item_reg;
        size_next     = size_reg;
        aln_next      = aln_reg;
        idx_next      = idx_reg;
        slot_next     = slot_reg;
        empty_next    = empty_reg;
        empty_ok_next = empty_ok_reg;
        claim_next    = claim_reg;
        rem_next      = rem_reg;
        nxt_next      = nxt_reg;
        cnt_next      = cnt_reg;
        start_next    = start_reg;
        end_next      = end_reg;
        added_next    = added_reg;
        res_st_next   = res_st_reg;
        res_loc_next  = res_loc_reg;
        rd_en         = 1'b0;
        wr_en         = 1'b0;
        wr_data       = '0;
        clr_all       = 1'b0;
        div_start     = 1'b0;
        div_a         = '0;
        div_b         = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_st_next  = ST_OK;
                    res_loc_next = '0;
                    item_next    = req.byte_count;
                    size_next    = req.byte_count;
                    aln_next     = req.alignment;
                    claim_next   = 1'b0;
                    case (req.action)
                        ACT_RESTART:
                        begin
                            clr_all    = 1'b1;
                            used_next  = '0;
                            ws_next    = start_size_reg;
                            state_next = S_DONE;
                        end
                        ACT_RAW:
                        begin
                            pool_mode_next = 1'b0;
                            state_next     = S_ALN;
                        end
                        ACT_POOL:
                        begin
                            pool_mode_next = 1'b1;
                            idx_next       = '0;
                            empty_ok_next  = 1'b0;
                            if (req.byte_count == '0)
                            begin
                                res_st_next = ST_ZERO_ITEM;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                state_next = S_SCAN_RD;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCAN_RD:
            begin
                rd_en      = 1'b1;
                state_next = S_SCAN_CK;
            end
            S_SCAN_CK:
            begin
                if (cur.item_size == item_reg)
                begin
                    slot_next  = idx_reg;
                    rem_next   = cur.remaining;
                    nxt_next   = cur.next_offset;
                    state_next = S_POOL;
                end
                else if (idx_reg == LAST_SLOT)
                begin
                    if (cur.item_size == '0 || empty_ok_reg)
                    begin
                        slot_next  = (cur.item_size == '0) ? idx_reg : empty_reg;
                        claim_next = 1'b1;
                        rem_next   = '0;
                        nxt_next   = '0;
                        state_next = S_POOL;
                    end
                    else
                    begin
                        res_st_next = ST_NO_POOL;
                        state_next  = S_DONE;
                    end
                end
                else
                begin
                    if (cur.item_size == '0)
                    begin
                        empty_next    = idx_reg;
                        empty_ok_next = 1'b1;
                    end
                    idx_next   = idx_reg + SW'(1);
                    state_next = S_SCAN_RD;
                end
            end
            S_POOL:
            begin
                div_start = 1'b1;
                div_b     = item_reg;
                if (rem_reg == '0)
                begin
                    div_a      = {2'b00, CHUNK_W};
                    state_next = S_CNT;
                end
                else
                begin
                    div_a      = {2'b00, nxt_reg};
                    state_next = S_IDX_WT;
                end
            end
            S_CNT:
            begin
                if (div_done)
                begin
                    if (div_q == '0)
                    begin
                        cnt_next  = DW'(1);
                        size_next = item_reg;
                    end
                    else
                    begin
                        cnt_next  = div_q[DW-1:0];
                        size_next = CHUNK_W - div_r;
                    end
                    aln_next   = item_reg;
                    state_next = S_ALN;
                end
            end
            S_ALN:
            begin
                if (aln_reg == '0)
                begin
                    start_next = {1'b0, used_reg};
                    state_next = S_FIT;
                end
                else
                begin
                    div_start  = 1'b1;
                    div_a      = {2'b00, used_reg};
                    div_b      = aln_reg;
                    state_next = S_ALN_WT;
                end
            end
            S_ALN_WT:
            begin
                if (div_done)
                begin
                    if (div_r == '0)
                    begin
                        start_next = {1'b0, used_reg};
                    end
                    else
                    begin
                        start_next = {1'b0, used_reg} + {1'b0, aln_reg - div_r};
                    end
                    state_next = S_FIT;
                end
            end
            S_FIT:
            begin
                end_next = {1'b0, start_reg} + {2'b00, size_reg};
                if (({1'b0, start_reg} + {2'b00, size_reg}) > {2'b00, ws_reg})
                begin
                    if (grow_step_reg == '0)
                    begin
                        res_st_next = ST_NO_GROW;
                        if (pool_mode_reg && claim_reg)
                        begin
                            wr_en   = 1'b1;
                            wr_data = '{item_size: item_reg, remaining: '0,
                                        next_offset: nxt_reg};
                        end
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_GROW_WT;
                    end
                end
                else
                begin
                    used_next = start_reg[DW-1:0] + size_reg;
                    if (pool_mode_reg)
                    begin
                        rem_next   = cnt_reg;
                        nxt_next   = start_reg[DW-1:0];
                        state_next = S_IDX;
                    end
                    else
                    begin
                        res_loc_next = start_reg[DW-1:0];
                        state_next   = S_DONE;
                    end
                end
            end
            S_GROW_WT:
            begin
                // division starts on entry, end_reg is stable here
                if (!div_done && added_reg != {(DW+3){1'b1}})
                begin
                    div_start  = 1'b1;
                    div_a      = need;
                    div_b      = grow_step_reg;
                    added_next = {(DW+3){1'b1}};
                end
                if (div_done)
                begin
                    added_next = {1'b0, need} - {3'b000, div_r}
                               + ((div_r != '0) ? {3'b000, grow_step_reg} : '0);
                    state_next = S_GROW_CK;
                end
            end
            S_GROW_CK:
            begin
                if ((size_limit_reg != '0 && new_ws > {4'b0000, size_limit_reg})
                    || new_ws[DW+3:DW] != 4'b0000)
                begin
                    res_st_next = ST_LIMIT;
                    if (pool_mode_reg && claim_reg)
                    begin
                        wr_en   = 1'b1;
                        wr_data = '{item_size: item_reg, remaining: '0,
                                    next_offset: nxt_reg};
                    end
                    state_next = S_DONE;
                end
                else
                begin
                    ws_next   = new_ws[DW-1:0];
                    used_next = end_reg[DW-1:0];
                    if (pool_mode_reg)
                    begin
                        rem_next   = cnt_reg;
                        nxt_next   = start_reg[DW-1:0];
                        state_next = S_IDX;
                    end
                    else
                    begin
                        res_loc_next = start_reg[DW-1:0];
                        state_next   = S_DONE;
                    end
                end
            end
            S_IDX:
            begin
                div_start  = 1'b1;
                div_a      = {2'b00, nxt_reg};
                div_b      = item_reg;
                state_next = S_IDX_WT;
            end
            S_IDX_WT:
            begin
                if (div_done)
                begin
                    res_loc_next = div_q[DW-1:0];
                    wr_en        = 1'b1;
                    wr_data      = '{item_size: item_reg,
                                     remaining: rem_reg - DW'(1),
                                     next_offset: nxt_reg + item_reg};
                    state_next   = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output register
    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (rsp.ready)
        begin
            out_vld_next = 1'b0;
        end
        if (out_load)
        begin
            out_vld_next = 1'b1;
        end
    end

    // control and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_vld_reg    <= 1'b0;
            used_reg       <= '0;
            ws_reg         <= START_RST;
            start_size_reg <= START_RST;
            grow_step_reg  <= GROW_RST;
            size_limit_reg <= LIMIT_RST;
            vld_reg        <= '0;
            added_reg      <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            out_vld_reg <= out_vld_next;
            used_reg    <= used_next;
            ws_reg      <= ws_next;
            // growth rounding uses added_reg as a started flag on entry
            if (state_reg == S_FIT)
            begin
                added_reg <= '0;
            end
            else
            begin
                added_reg <= added_next;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_START: start_size_reg <= cfg_data;
                    CFG_GROW:  grow_step_reg  <= cfg_data;
                    CFG_LIMIT: size_limit_reg <= cfg_data;
                    default:   start_size_reg <= start_size_reg;
                endcase
            end
            if (clr_all)
            begin
                vld_reg <= '0;
            end
            else if (wr_en)
            begin
                vld_reg[slot_reg] <= 1'b1;
            end
        end
    end

    // request payload registers
    always_ff @(posedge clk)
    begin
        pool_mode_reg <= pool_mode_next;
        item_reg      <= item_next;
        size_reg      <= size_next;
        aln_reg       <= aln_next;
        idx_reg       <= idx_next;
        slot_reg      <= slot_next;
        empty_reg     <= empty_next;
        empty_ok_reg  <= empty_ok_next;
        claim_reg     <= claim_next;
        rem_reg       <= rem_next;
        nxt_reg       <= nxt_next;
        cnt_reg       <= cnt_next;
        start_reg     <= start_next;
        end_reg       <= end_next;
        res_st_reg    <= res_st_next;
        res_loc_reg   <= res_loc_next;
        if (out_load)
        begin
            out_st_reg  <= res_st_reg;
            out_loc_reg <= (res_st_reg == ST_OK) ? res_loc_reg : '0;
        end
    end

    // pool table memory: one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[slot_reg] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[idx_reg];
            rd_vld_reg  <= vld_reg[idx_reg];
        end
    end

    assign rsp.valid    = out_vld_reg;
    assign rsp.status   = out_st_reg;
    assign rsp.location = out_loc_reg;
endmodule
`default_nettype wire

[rtl/pba_check.sv]
// port-level checker for the pooled bump allocator, bound to the top level
// depends on pba_pkg and pooled_bump_allocator_assert.svh
`timescale 1ns / 1ps
`default_nettype none
`include "pooled_bump_allocator_assert.svh"
module pba_check (
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   in_valid,
    input wire logic                   in_ready,
    input wire logic [1:0]             in_action,
    input wire logic                   out_valid,
    input wire logic                   out_ready,
    input wire logic [2:0]             out_status,
    input wire logic [pba_pkg::DW-1:0] out_location
);
    import pba_pkg::*;

    // a held result stays offered
    `PBA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
    // a dropped code leaves the block idle
    `PBA_ASSERT_NEXT(a_drop_idle, in_valid && in_ready && in_action == ACT_NONE, in_ready)
    // a real request makes the block busy in the cycle after it is taken
    `PBA_ASSERT_NEXT(a_busy, in_valid && in_ready && in_action != ACT_NONE, !in_ready)
    // a failed request reports no location
    `PBA_ASSERT_NOW(a_fail_loc, out_valid && out_status != ST_OK, out_location == '0)
endmodule

bind pooled_bump_allocator pba_check u_pba_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (req.valid),
    .in_ready     (req.ready),
    .in_action    (req.action),
    .out_valid    (rsp.valid),
    .out_ready    (rsp.ready),
    .out_status   (rsp.status),
    .out_location (rsp.location)
);
`default_nettype wire

[sim/tb_pooled_bump_allocator.sv]
// testbench for the pooled bump allocator: directed and random requests
// checked against a behavioral model of the allocator state
// depends on pba_pkg, pba_if and pooled_bump_allocator
`timescale 1ns / 1ps
`default_nettype none
module tb_pooled_bump_allocator;
    import pba_pkg::*;

    localparam int SLOTS = 12;
    localparam int CHUNK = 20480;
    localparam longint CYCLE_LIMIT = 3000000;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [31:0] cfg_data;

    pba_req_if req ();
    pba_rsp_if rsp ();

    pooled_bump_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req.sink),
        .rsp       (rsp.source)
    );

    // expected result of one request
    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] location;
    } alloc_result_t;

    // allocator model state
    logic [31:0] m_start;
    logic [31:0] m_grow;
    logic [31:0] m_limit;
    logic [31:0] m_used;
    logic [31:0] m_space;
    logic [31:0] m_isize [SLOTS];
    logic [31:0] m_remain [SLOTS];
    logic [31:0] m_next [SLOTS];

    alloc_result_t pending_results[$];
    int mismatches;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_cycles;
    longint cycle_count;

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // grow the workspace to fit need more bytes
    function automatic logic [2:0] model_grow(logic [63:0] need);
        logic [63:0] steps;
        logic [63:0] new_size;
        if (m_grow == 0)
            return ST_NO_GROW;
        steps = need / m_grow;
        if (need % m_grow != 0)
            steps++;
        if (steps == 0)
            steps = 1;
        new_size = 64'(m_space) + steps * m_grow;
        if (m_limit != 0 && new_size > m_limit)
            return ST_LIMIT;
        if (new_size > 64'hFFFF_FFFF)
            return ST_LIMIT;
        m_space = new_size[31:0];
        return ST_OK;
    endfunction

    // bump allocation with alignment
    function automatic logic [2:0] model_bump(logic [63:0] size, logic [63:0] aln,
                                              output logic [31:0] where);
        logic [63:0] first;
        logic [63:0] last;
        logic [2:0] st;
        first = m_used;
        where = 0;
        if (aln != 0 && first % aln != 0)
            first += aln - first % aln;
        last = first + size;
        if (last > m_space)
        begin
            st = model_grow(last - m_space);
            if (st != ST_OK)
                return st;
        end
        m_used = last[31:0];
        where = first[31:0];
        return ST_OK;
    endfunction

    // pool allocation from a size-class pool
    function automatic logic [2:0] model_pool(logic [31:0] item, output logic [31:0] where);
        int slot;
        int empty;
        logic [31:0] cnt;
        logic [31:0] base;
        logic [2:0] st;
        slot = SLOTS;
        empty = SLOTS;
        where = 0;
        if (item == 0)
            return ST_ZERO_ITEM;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (m_isize[i] == 0)
                empty = i;
            if (m_isize[i] == item)
            begin
                slot = i;
                break;
            end
        end
        if (slot == SLOTS)
        begin
            if (empty == SLOTS)
                return ST_NO_POOL;
            slot = empty;
            m_isize[slot] = item;
            m_remain[slot] = 0;
        end
        if (m_remain[slot] == 0)
        begin
            cnt = CHUNK / item;
            if (cnt == 0)
                cnt = 1;
            st = model_bump(64'(cnt) * item, 64'(item), base);
            if (st != ST_OK)
                return st;
            m_remain[slot] = cnt;
            m_next[slot] = base;
        end
        m_remain[slot]--;
        where = m_next[slot] / item;
        m_next[slot] = m_next[slot] + item;
        return ST_OK;
    endfunction

    function automatic void model_restart();
        m_used = 0;
        m_space = m_start;
        for (int i = 0; i < SLOTS; i++)
        begin
            m_isize[i] = 0;
            m_remain[i] = 0;
            m_next[i] = 0;
        end
    endfunction

    // predict and queue the result of one accepted request
    function automatic void predict_alloc(logic [1:0] act, logic [31:0] cnt, logic [31:0] aln);
        alloc_result_t r;
        logic [31:0] where;
        where = 0;
        r.status = ST_OK;
        if (act == ACT_RESTART)
            model_restart();
        else if (act == ACT_RAW)
            r.status = model_bump(64'(cnt), 64'(aln), where);
        else if (act == ACT_POOL)
            r.status = model_pool(cnt, where);
        else
            return;
        r.location = (r.status == ST_OK) ? where : 32'd0;
        pending_results.push_back(r);
    endfunction

    // send one request, with random idle cycles before it
    // valid stays high after the transaction until the next idle or drain
    task automatic send_request(logic [1:0] act, logic [31:0] cnt, logic [31:0] aln);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid <= 1'b1;
        req.action <= act;
        req.byte_count <= cnt;
        req.alignment <= aln;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        predict_alloc(act, cnt, aln);
    endtask

    task automatic wait_drained();
        req.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_START)
            m_start = val;
        else if (idx == CFG_GROW)
            m_grow = val;
        else if (idx == CFG_LIMIT)
            m_limit = val;
        @(posedge clk);
    endtask

    // receiver side: random stalls and long hold-off
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            rsp.ready <= 1'b0;
        end
        else
            rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // compare each result transaction with the oldest expectation
    always @(posedge clk)
    begin
        alloc_result_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result status=%0d location=%0d",
                             rsp.status, rsp.location);
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp.status !== want.status || rsp.location !== want.location)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected status=%0d location=%0d, got %0d %0d",
                                 want.status, want.location, rsp.status, rsp.location);
                end
            end
        end
    end

    // cycle limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // directed: extremes, every action and special cases
    task automatic test_directed();
        send_request(ACT_RAW, 32'd10, 32'd0);
        send_request(ACT_RAW, 32'd1, 32'd8);
        send_request(ACT_RAW, 32'd3, 32'hFFFF_FFFF);
        send_request(ACT_RAW, 32'hFFFF_FFFF, 32'd0);
        send_request(ACT_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(ACT_POOL, 32'd0, 32'd0);
        send_request(ACT_POOL, 32'd24, 32'd0);
        send_request(ACT_POOL, 32'd24, 32'd0);
        send_request(ACT_POOL, 32'd30000, 32'd0);
        send_request(ACT_POOL, 32'd30000, 32'd0);
        for (int i = 1; i <= 12; i++)
            send_request(ACT_POOL, 32'(i * 100 + 1), 32'd0);
        send_request(ACT_RAW, 32'd50_000_000, 32'd16);
        send_request(ACT_RESTART, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        wait_drained();
    endtask

    // growth disabled, then tight limit and pool refill failures
    task automatic test_growth_limits();
        write_reg(CFG_GROW, 32'd0);
        write_reg(CFG_START, 32'd4096);
        send_request(ACT_RESTART, 0, 0);
        send_request(ACT_RAW, 32'd5000, 32'd0);
        send_request(ACT_POOL, 32'd8, 32'd0);
        send_request(ACT_POOL, 32'd8, 32'd0);
        wait_drained();
        write_reg(CFG_GROW, 32'd4096);
        write_reg(CFG_LIMIT, 32'd65536);
        send_request(ACT_RESTART, 0, 0);
        for (int i = 0; i < 8; i++)
            send_request(ACT_POOL, 32'd16, 32'd0);
        send_request(ACT_RAW, 32'd100000, 32'd4);
        wait_drained();
        write_reg(CFG_START, 32'hFFFF_FFFF);
        write_reg(CFG_GROW, 32'hFFFF_FFFF);
        write_reg(CFG_LIMIT, 32'd0);
        send_request(ACT_RESTART, 0, 0);
        send_request(ACT_RAW, 32'hFFFF_FFFF, 32'd0);
        send_request(ACT_RAW, 32'd1, 32'd0);
        wait_drained();
    endtask

    // random phase with given idle mix
    task automatic test_random(int n, int s_pct, int r_pct);
        logic [1:0] act;
        logic [31:0] cnt;
        logic [31:0] aln;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (int k = 0; k < n; k++)
        begin
            case ($urandom_range(99)) inside
                [0:2]:   act = ACT_RESTART;
                [3:4]:   act = ACT_NONE;
                [5:44]:  act = ACT_RAW;
                default: act = ACT_POOL;
            endcase
            case ($urandom_range(9))
                0:       cnt = $urandom;
                1:       cnt = $urandom_range(30000, 20000);
                2, 3:    cnt = $urandom_range(4096);
                default: cnt = 32'd1 << $urandom_range(7);
            endcase
            case ($urandom_range(5))
                0:       aln = $urandom;
                1:       aln = 0;
                default: aln = 32'd1 << $urandom_range(12);
            endcase
            send_request(act, cnt, aln);
        end
    endtask

    // receiver holds off while requests keep coming, then sender pauses
    task automatic test_backpressure();
        hold_cycles = 400;
        for (int k = 0; k < 20; k++)
            send_request(ACT_RAW, $urandom_range(64), 32'd8);
        wait_drained();
    endtask

    initial
    begin
        rst_n = 1'b0;
        clk = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_START;
        cfg_data = 0;
        req.valid = 1'b0;
        req.action = ACT_RESTART;
        req.byte_count = 0;
        req.alignment = 0;
        rsp.ready = 1'b0;
        mismatches = 0;
        hold_cycles = 0;
        cycle_count = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        m_start = START_RST;
        m_grow = GROW_RST;
        m_limit = LIMIT_RST;
        model_restart();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_growth_limits();
        write_reg(CFG_START, 32'd65536);
        write_reg(CFG_GROW, 32'd16384);
        write_reg(CFG_LIMIT, 32'd0);
        send_request(ACT_RESTART, 0, 0);
        test_random(560, 13, 56);
        wait_drained();
        write_reg(CFG_START, 32'd0);
        write_reg(CFG_GROW, 32'd1);
        write_reg(CFG_LIMIT, 32'hFFFF_FFFF);
        test_random(560, 56, 13);
        wait_drained();
        write_reg(CFG_START, START_RST);
        write_reg(CFG_GROW, GROW_RST);
        write_reg(CFG_LIMIT, 32'h0200_0000);
        test_random(560, 0, 0);
        test_backpressure();

        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
`default_nettype wire
